// File: sv/haversine_distance_unit_assert.svh
// assertion macros for the haversine distance unit
`ifndef HAVERSINE_DISTANCE_UNIT_ASSERT_SVH
`define HAVERSINE_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication
`define HDU_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hdu: implication failed");

// next-cycle implication
`define HDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hdu: next-cycle check failed");

// implication after a fixed delay
`define HDU_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("hdu: delayed check failed");

`endif

// File: sv/hdu_pkg.sv
package hdu_pkg;

  localparam int CORDIC_STAGES = 30;
  localparam int SQRT_STAGES   = 32;
  localparam int LANES         = 4;

  // pipeline positions
  localparam int P_Z      = 3;
  localparam int P_M1     = P_Z + CORDIC_STAGES + 1;
  localparam int P_M3     = P_M1 + 2;
  localparam int P_SQ_END = P_M3 + SQRT_STAGES;
  localparam int P_V_END  = P_SQ_END + CORDIC_STAGES;
  localparam int LATENCY  = P_V_END + 2;

  typedef logic signed [33:0] q_t;

  localparam q_t Q30_ONE   = 34'sd1073741824;
  localparam q_t GAIN_INV  = 34'sd652032874;
  localparam q_t DEG90     = 34'sd754974720;
  localparam q_t DEG180    = 34'sd1509949440;
  localparam q_t DEG360    = 34'sd3019898880;

  localparam logic [34:0] DEG2RAD_K = 35'd19190098069;
  localparam logic [17:0] K_HI      = DEG2RAD_K[34:17];
  localparam logic [16:0] K_LO      = DEG2RAD_K[16:0];

  localparam logic [15:0] RADIUS_RESET = 16'd6371;

  typedef enum logic [1:0] {
    OP_FULL  = 2'd0,
    OP_EAST  = 2'd1,
    OP_NORTH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       neg;
    logic [1:0] cneg;
  } side_t;

  typedef struct packed {
    logic neg;
    q_t   ang;
  } fold_t;

  // arctangent table in q2.30
  function automatic q_t atan_entry(input int i);
    q_t v;
    v = '0;
    unique case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: begin
        if (i <= 30) v = q_t'(64'sd1 <<< (30 - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

  // q2.30 product, rounded half up
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return q_t'(p >>> 30);
  endfunction

  // fold a cosine angle into [-90, 90] degrees
  function automatic fold_t fold_cos(input q_t d);
    fold_t f;
    f.neg = 1'b0;
    f.ang = d;
    if (d > DEG90) begin
      f.ang = d - DEG180;
      f.neg = 1'b1;
    end else if (d < -DEG90) begin
      f.ang = d + DEG180;
      f.neg = 1'b1;
    end
    return f;
  endfunction

  // reduce a sine-squared angle modulo 180 degrees into (-90, 90]
  function automatic q_t fold_sin(input q_t d);
    q_t r;
    if (d >= DEG180) r = d - DEG180;
    else if (d >= 0) r = d;
    else if (d > -DEG180) r = d + DEG180;
    else if (d == -DEG180) r = '0;
    else r = d + DEG360;
    if (r > DEG90) r = r - DEG180;
    return r;
  endfunction

endpackage

// File: sv/haversine_distance_unit.sv
// throughput: one item per cycle, set by the fully unrolled cordic and root pipelines
// busy is high only while rst_n is low; the result strobe cannot be held off
// reset (synchronous, active low) clears the valid pipeline and sets the radius to 6371
`include "haversine_distance_unit_assert.svh"

module haversine_distance_unit
  import hdu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [30:0] in_from_longitude,
  input  logic signed [29:0] in_from_latitude,
  input  logic signed [30:0] in_to_longitude,
  input  logic signed [29:0] in_to_latitude,
  output logic               out_valid,
  output logic signed [31:0] out_distance,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0] radius_r;
  logic        vld_r  [1:LATENCY];
  side_t       side_r [1:LATENCY];

  q_t          ang_r  [LANES];
  logic        s2_neg_r [LANES];
  logic [47:0] pph_r  [LANES];
  logic [46:0] ppl_r  [LANES];

  q_t rx_r [0:CORDIC_STAGES][LANES];
  q_t ry_r [0:CORDIC_STAGES][LANES];
  q_t rz_r [0:CORDIC_STAGES][LANES];

  q_t cc_r, sl_r, so_r, t_r, sl2_r;

  logic [63:0] sq_n_r   [0:SQRT_STAGES][2];
  logic [63:0] sq_res_r [0:SQRT_STAGES][2];

  q_t vx_r [1:CORDIC_STAGES];
  q_t vy_r [1:CORDIC_STAGES];
  q_t vz_r [1:CORDIC_STAGES];

  logic signed [50:0] prod_r;
  logic signed [31:0] dist_r;

  side_t side_nxt;
  fold_t fc0, fc1;
  q_t    dlat, dlon;
  q_t    a_sum, a_clamp;
  logic signed [37:0] q_scaled;
  logic signed [39:0] d_signed;
  logic signed [31:0] dist_nxt;

  assign busy         = !rst_n;
  assign out_valid    = vld_r[LATENCY];
  assign out_distance = dist_r;

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RADIUS_RESET;
    else if (cfg_we) radius_r <= cfg_wdata;
  end

  // valid and side band travel together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 1; p <= LATENCY; p++) vld_r[p] <= 1'b0;
    end else begin
      vld_r[1] <= start && !busy;
      for (int p = 2; p <= LATENCY; p++) vld_r[p] <= vld_r[p-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= side_nxt;
    for (int p = 2; p <= LATENCY; p++) side_r[p] <= side_r[p-1];
  end

  // angle reduction and sign decisions
  always_comb begin
    fc0  = fold_cos(q_t'($signed({in_from_latitude, 1'b0})));
    fc1  = fold_cos(q_t'($signed({in_to_latitude, 1'b0})));
    dlat = q_t'(in_to_latitude) - q_t'(in_from_latitude);
    dlon = q_t'(in_to_longitude) - q_t'(in_from_longitude);
    side_nxt.op   = op_t'(in_operation);
    side_nxt.cneg = {fc1.neg, fc0.neg};
    unique case (op_t'(in_operation))
      OP_EAST:  side_nxt.neg = !(in_to_longitude > in_from_longitude);
      OP_NORTH: side_nxt.neg = !(in_from_latitude > in_to_latitude);
      default:  side_nxt.neg = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    ang_r[0] <= fc0.ang;
    ang_r[1] <= fc1.ang;
    ang_r[2] <= fold_sin(dlat);
    ang_r[3] <= fold_sin(dlon);
  end

  // degrees to radians, partial products on the unsigned magnitude
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      s2_neg_r[l] <= ang_r[l] < 0;
      pph_r[l]    <= 48'($unsigned((ang_r[l] < 0) ? 30'(-ang_r[l]) : 30'(ang_r[l])))
                     * 48'(K_HI);
      ppl_r[l]    <= 47'($unsigned((ang_r[l] < 0) ? 30'(-ang_r[l]) : 30'(ang_r[l])))
                     * 47'(K_LO);
    end
  end

  // sum, round and restore the sign into the cordic angle
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      rx_r[0][l] <= GAIN_INV;
      ry_r[0][l] <= '0;
      rz_r[0][l] <= s2_neg_r[l]
        ? -q_t'({3'b000, 31'(({pph_r[l], 17'b0} + 65'(ppl_r[l]) + (65'd1 << 32)) >> 33)})
        :  q_t'({3'b000, 31'(({pph_r[l], 17'b0} + 65'(ppl_r[l]) + (65'd1 << 32)) >> 33)});
    end
  end

  // rotation cordic, four lanes
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        if (rz_r[k][l] >= 0) begin
          rx_r[k+1][l] <= rx_r[k][l] - (ry_r[k][l] >>> k);
          ry_r[k+1][l] <= ry_r[k][l] + (rx_r[k][l] >>> k);
          rz_r[k+1][l] <= rz_r[k][l] - atan_entry(k);
        end else begin
          rx_r[k+1][l] <= rx_r[k][l] + (ry_r[k][l] >>> k);
          ry_r[k+1][l] <= ry_r[k][l] - (rx_r[k][l] >>> k);
          rz_r[k+1][l] <= rz_r[k][l] + atan_entry(k);
        end
      end
    end
  end

  // cosine product and sine squares
  always_ff @(posedge clk) begin
    cc_r <= mulq(side_r[P_M1-1].cneg[0] ? -rx_r[CORDIC_STAGES][0] : rx_r[CORDIC_STAGES][0],
                 side_r[P_M1-1].cneg[1] ? -rx_r[CORDIC_STAGES][1] : rx_r[CORDIC_STAGES][1]);
    sl_r <= mulq(ry_r[CORDIC_STAGES][2], ry_r[CORDIC_STAGES][2]);
    so_r <= mulq(ry_r[CORDIC_STAGES][3], ry_r[CORDIC_STAGES][3]);
  end

  // longitude term
  always_ff @(posedge clk) begin
    t_r   <= mulq(cc_r, so_r);
    sl2_r <= sl_r;
  end

  // haversine term, clamped to [0, 1]
  always_comb begin
    unique case (side_r[P_M3-1].op)
      OP_FULL: a_sum = sl2_r + t_r;
      OP_EAST: a_sum = t_r;
      default: a_sum = sl2_r;
    endcase
    priority if (a_sum < 0) a_clamp = '0;
    else if (a_sum > Q30_ONE) a_clamp = Q30_ONE;
    else a_clamp = a_sum;
  end

  always_ff @(posedge clk) begin
    sq_n_r[0][0]   <= {3'b000, a_clamp[30:0], 30'b0};
    sq_n_r[0][1]   <= {3'b000, 31'(Q30_ONE - a_clamp), 30'b0};
    sq_res_r[0][0] <= '0;
    sq_res_r[0][1] <= '0;
  end

  // integer square roots, one result bit a stage
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - j));
    always_ff @(posedge clk) begin
      for (int l = 0; l < 2; l++) begin
        if (sq_n_r[j][l] >= sq_res_r[j][l] + BIT) begin
          sq_n_r[j+1][l]   <= sq_n_r[j][l] - (sq_res_r[j][l] + BIT);
          sq_res_r[j+1][l] <= (sq_res_r[j][l] >> 1) + BIT;
        end else begin
          sq_n_r[j+1][l]   <= sq_n_r[j][l];
          sq_res_r[j+1][l] <= sq_res_r[j][l] >> 1;
        end
      end
    end
  end

  // vectoring cordic for atan2(sqrt a, sqrt(1 - a)), fed straight from the roots
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    q_t xk, yk, zk;
    if (k == 0) begin : g_root
      assign xk = $signed(sq_res_r[SQRT_STAGES][1][33:0]);
      assign yk = $signed(sq_res_r[SQRT_STAGES][0][33:0]);
      assign zk = '0;
    end else begin : g_chain
      assign xk = vx_r[k];
      assign yk = vy_r[k];
      assign zk = vz_r[k];
    end
    always_ff @(posedge clk) begin
      if (yk > 0) begin
        vx_r[k+1] <= xk + (yk >>> k);
        vy_r[k+1] <= yk - (xk >>> k);
        vz_r[k+1] <= zk + atan_entry(k);
      end else begin
        vx_r[k+1] <= xk - (yk >>> k);
        vy_r[k+1] <= yk + (xk >>> k);
        vz_r[k+1] <= zk - atan_entry(k);
      end
    end
  end

  // radius scaling
  always_ff @(posedge clk) begin
    prod_r <= 51'($signed({1'b0, radius_r})) * 51'(vz_r[CORDIC_STAGES]);
  end

  // rounding, sign and saturation
  always_comb begin
    q_scaled = 38'((prod_r + 51'sd4096) >>> 13);
    d_signed = side_r[LATENCY-1].neg ? -40'(q_scaled) : 40'(q_scaled);
    priority if (side_r[LATENCY-1].op == OP_NONE) dist_nxt = '0;
    else if (d_signed > 40'sd2147483647) dist_nxt = 32'sh7fffffff;
    else if (d_signed < -40'sd2147483648) dist_nxt = 32'sh80000000;
    else dist_nxt = d_signed[31:0];
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  // assertions
  `HDU_ASSERT_DELAY(a_latency, start && !busy, LATENCY, out_valid)
  `HDU_ASSERT_NEXT(a_unused_op_zero, vld_r[LATENCY-1] && side_r[LATENCY-1].op == OP_NONE, out_distance == 32'sd0)
  `HDU_ASSERT_IMPLIES(a_root_bound, vld_r[P_SQ_END], sq_res_r[SQRT_STAGES][0] <= 64'd1073741824 && sq_res_r[SQRT_STAGES][1] <= 64'd1073741824)

endmodule

// File: bench/haversine_distance_unit_test.sv
`timescale 1ns / 100ps

module haversine_distance_unit_test
  import hdu_pkg::*;
;

  typedef struct {
    op_t                op;
    logic signed [30:0] lon1;
    logic signed [29:0] lat1;
    logic signed [30:0] lon2;
    logic signed [29:0] lat2;
  } point_pair_t;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam longint LAT_MAX = 377487360;
  localparam longint LON_MAX = 754974720;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = '0;
  logic signed [30:0] in_from_longitude = '0;
  logic signed [29:0] in_from_latitude = '0;
  logic signed [30:0] in_to_longitude = '0;
  logic signed [29:0] in_to_latitude = '0;
  logic               out_valid;
  logic signed [31:0] out_distance;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;

  point_pair_t        pending_pairs[$];
  logic signed [31:0] expected_distances[$];
  logic [15:0]        radius_model = RADIUS_RESET;
  int                 mismatch_count = 0;
  int                 quiet_cycles = 0;
  bit                 idling_on = 1'b1;
  int                 gap_left = 0;

  haversine_distance_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation),
    .in_from_longitude(in_from_longitude), .in_from_latitude(in_from_latitude),
    .in_to_longitude(in_to_longitude), .in_to_latitude(in_to_latitude),
    .out_valid(out_valid), .out_distance(out_distance),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // arctangent of 2^-i in q2.30
  function automatic longint arctan_step(input int i);
    longint heads[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                          33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return heads[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint q30_product(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // deg * 2^23 within +-90 degrees to radians in q2.30
  function automatic longint to_radians(input longint d);
    logic [63:0] mag;
    logic [63:0] r;
    mag = (d < 0) ? -d : d;
    r = (mag * 64'd19190098069 + (64'd1 << 32)) >> 33;
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  // rotation mode, returns cosine and sine
  function automatic void rotate_angle(input longint z, output longint c, output longint s);
    longint x, y, xs, ys;
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    c = x;
    s = y;
  endfunction

  // vectoring mode, returns angle
  function automatic longint vector_angle(input longint x, input longint y);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_step(i);
      end else begin
        x -= ys; y += xs; z -= arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint cosine_of(input longint d);
    longint r, c, s;
    bit flip;
    flip = 1'b0;
    r = d % 64'sd3019898880;
    if (r < 0) r += 64'sd3019898880;
    if (r > 1509949440) r -= 64'sd3019898880;
    if (r > LON_MAX) begin
      r -= 1509949440; flip = 1'b1;
    end else if (r < -LON_MAX) begin
      r += 1509949440; flip = 1'b1;
    end
    rotate_angle(to_radians(r), c, s);
    return flip ? -c : c;
  endfunction

  function automatic longint sine_squared_of(input longint d);
    longint r, c, s;
    r = d % 1509949440;
    if (r < 0) r += 1509949440;
    if (r > LON_MAX) r -= 1509949440;
    rotate_angle(to_radians(r), c, s);
    return q30_product(s, s);
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] predict_distance(input point_pair_t p,
                                                          input logic [15:0] radius);
    longint lo1, la1, lo2, la2, a, cc, theta, d, sgn;
    logic [63:0] sy, sx;
    lo1 = p.lon1; la1 = p.lat1; lo2 = p.lon2; la2 = p.lat2;
    sgn = 1;
    case (p.op)
      OP_NONE: return '0;
      OP_FULL: begin
        cc = q30_product(cosine_of(la1 * 2), cosine_of(la2 * 2));
        a = sine_squared_of(la2 - la1) + q30_product(cc, sine_squared_of(lo2 - lo1));
      end
      OP_EAST: begin
        cc = q30_product(cosine_of(la1 * 2), cosine_of(la2 * 2));
        a = q30_product(sine_squared_of(lo2 - lo1), cc);
        sgn = (lo2 > lo1) ? 1 : -1;
      end
      default: begin
        a = sine_squared_of(la2 - la1);
        sgn = (la1 > la2) ? 1 : -1;
      end
    endcase
    if (a < 0) a = 0;
    if (a > 1073741824) a = 1073741824;
    sy = floor_root(64'(a) << 30);
    sx = floor_root(64'(1073741824 - a) << 30);
    theta = vector_angle(longint'(sx), longint'(sy));
    d = ((longint'(radius) * theta + 4096) >>> 13) * sgn;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d[31:0];
  endfunction

  // driver: one transfer per accepted start, random idle bursts
  always @(posedge clk) begin
    point_pair_t p;
    logic next_start;
    if (rst_n) begin
      next_start = start;
      if (!start || !busy) begin
        next_start = 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (idling_on && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 13);
        else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          next_start = 1'b1;
          in_operation      <= p.op;
          in_from_longitude <= p.lon1;
          in_from_latitude  <= p.lat1;
          in_to_longitude   <= p.lon2;
          in_to_latitude    <= p.lat2;
        end
      end
      start <= next_start;
    end
  end

  // monitor: predict on input transfer, compare on result strobe
  always @(posedge clk) begin
    point_pair_t p;
    logic signed [31:0] want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we) radius_model = cfg_wdata;
      if (start && !busy) begin
        p.op = op_t'(in_operation);
        p.lon1 = in_from_longitude; p.lat1 = in_from_latitude;
        p.lon2 = in_to_longitude;   p.lat2 = in_to_latitude;
        expected_distances.push_back(predict_distance(p, radius_model));
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        if (expected_distances.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: distance %0d", out_distance);
        end else begin
          want = expected_distances.pop_front();
          if (out_distance !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("distance mismatch: expected %0d, got %0d", want, out_distance);
          end
        end
      end
      // watchdog on cycles with no transfer at all
      if (moved || (pending_pairs.size() == 0 && !start && expected_distances.size() == 0))
        quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("haversine_distance_unit regression: fail");
        $finish;
      end else quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [29:0] pick_latitude();
    if ($urandom_range(0, 19) == 0) return 30'($urandom());
    return 30'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic signed [30:0] pick_longitude();
    if ($urandom_range(0, 19) == 0) return 31'($urandom());
    return 31'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
  endfunction

  task automatic queue_pair(input op_t op, input longint lo1, input longint la1,
                            input longint lo2, input longint la2);
    point_pair_t p;
    p.op = op;
    p.lon1 = 31'(lo1); p.lat1 = 30'(la1); p.lon2 = 31'(lo2); p.lat2 = 30'(la2);
    pending_pairs.push_back(p);
  endtask

  // random pairs: half nearby points, half anywhere, a few unused operations
  task automatic queue_random(input int count);
    point_pair_t p;
    op_t op;
    repeat (count) begin
      op = op_t'($urandom_range(0, 2));
      if ($urandom_range(0, 29) == 0) op = OP_NONE;
      p.lon1 = pick_longitude();
      p.lat1 = pick_latitude();
      if ($urandom_range(0, 1) == 0) begin
        p.lon2 = p.lon1 + 31'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        p.lat2 = p.lat1 + 30'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      end else begin
        p.lon2 = pick_longitude();
        p.lat2 = pick_latitude();
      end
      queue_pair(op, p.lon1, p.lat1, p.lon2, p.lat2);
    end
  endtask

  // let the block drain before a register write
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_pairs.size() != 0 || start || expected_distances.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radius(input logic [15:0] r);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] radii[5] = '{16'd1, 16'd65535, 16'd0, 16'd6371, 16'd0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed pairs at the reset radius
    queue_pair(OP_FULL, 0, 0, 0, 0);
    queue_pair(OP_FULL, -LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX);
    queue_pair(OP_FULL, 0, 0, LON_MAX, 0);
    queue_pair(OP_FULL, 0, LAT_MAX, 0, -LAT_MAX);
    queue_pair(OP_EAST, 0, 0, 4194304, 0);
    queue_pair(OP_EAST, 4194304, 0, 0, 0);
    queue_pair(OP_EAST, 123456, 1000, 123456, 2000);
    queue_pair(OP_EAST, -LON_MAX, LAT_MAX, LON_MAX, LAT_MAX);
    queue_pair(OP_NORTH, 0, 4194304, 0, 0);
    queue_pair(OP_NORTH, 0, 0, 0, 4194304);
    queue_pair(OP_NORTH, 0, 555, 0, 555);
    queue_pair(OP_NORTH, 0, LAT_MAX, 0, -LAT_MAX);
    queue_pair(OP_NONE, LON_MAX, LAT_MAX, -LON_MAX, -LAT_MAX);
    queue_pair(OP_FULL, 1073741823, 536870911, -1073741824, -536870912);
    queue_pair(OP_EAST, -1073741824, 536870911, 1073741823, 536870911);
    queue_pair(OP_NORTH, 0, -536870912, 0, 536870911);
    queue_pair(OP_FULL, 0, 536870911, 1000, 536870911);
    queue_pair(OP_FULL, 0, 0, 1, 1);
    queue_random(300);
    wait_drained();

    // one phase per radius, the last without idling
    for (int k = 0; k < 5; k++) begin
      write_radius(k == 4 ? 16'($urandom_range(2, 65534)) : radii[k]);
      if (k == 4) idling_on = 1'b0;
      queue_random(k == 2 ? 100 : 290);
      wait_drained();
    end

    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_distances.size() == 0)
      $display("haversine_distance_unit regression: pass");
    else
      $display("haversine_distance_unit regression: fail");
    $finish;
  end

endmodule
